### rtl/dlfs_pkg.sv
package dlfs_pkg;

    localparam int MAX_COLUMNS_DEFAULT = 15;
    localparam int SLOT_BITS_DEFAULT   = 4;

    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;

    // Columns are counted in four bits and stop at fifteen.
    localparam logic [3:0] COL_TOP = 4'd15;

    // Result queue geometry; the depth must stay a power of two.
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 3;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_FIRST       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIM_SECOND      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMENT_MARK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_BLANK_LINES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_EMPTY_FIELDS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COLUMN        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_MAP        = 3'd6;

    localparam logic [7:0]  RST_DELIM_FIRST       = 8'd32;
    localparam logic [7:0]  RST_DELIM_SECOND      = 8'd9;
    localparam logic [7:0]  RST_COMMENT_MARK      = 8'd35;
    localparam logic        RST_DROP_BLANK_LINES  = 1'b1;
    localparam logic        RST_SKIP_EMPTY_FIELDS = 1'b1;
    localparam logic [3:0]  RST_MAX_COLUMN        = 4'd15;
    localparam logic [63:0] RST_COLUMN_MAP        = 64'd0;

    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_CONTENT = 2'd1,
        PH_WAIT    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_FEW = 2'd1,
        ST_EOF = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0]  delim_first;
        logic [7:0]  delim_second;
        logic [7:0]  comment_mark;
        logic        drop_blank_lines;
        logic        skip_empty_fields;
        logic [3:0]  max_column;
        logic [63:0] column_map;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        has_byte;
        logic [3:0]  slot;
        logic [3:0]  column_index;
        logic        field_done;
        logic        line_done;
        status_t     status;
        logic [31:0] line_number;
        logic        last_result;
    } result_t;

    function automatic logic [3:0] col_inc(logic [3:0] col);
        return (col == COL_TOP) ? col : col + 4'd1;
    endfunction

    function automatic logic [3:0] slot_of(logic [63:0] map, logic [3:0] col,
                                           logic [3:0] mask);
        return map[{col, 2'b00} +: 4] & mask;
    endfunction

endpackage

### rtl/delimited_line_field_splitter_unit.sv
// Splits a text stream, one byte per request, into lines and fields and emits
// field bytes, field ends and line status as result requests. A new request is
// taken every clock cycle as long as results keep draining: the parser works
// on the request in the accept cycle and writes its results into a four-entry
// result queue, which registers them; they are offered once earlier results have drained.
// The input stalls whenever fewer than two queue entries are free, because an
// end-of-input request can produce two results (closing the open line, then
// the end-of-file report). Configuration registers are written through the
// plain write port and should only change while no results are pending.
module delimited_line_field_splitter_unit #(
    parameter int MAX_COLUMNS = dlfs_pkg::MAX_COLUMNS_DEFAULT,
    parameter int SLOT_BITS   = dlfs_pkg::SLOT_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_we,
    input  logic [dlfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dlfs_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [7:0]                     text_byte,
    input  logic                           end_of_input,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [7:0]                     out_byte,
    output logic                           has_byte,
    output logic [3:0]                     slot,
    output logic [3:0]                     column_index,
    output logic                           field_done,
    output logic                           line_done,
    output logic [1:0]                     status,
    output logic [31:0]                    line_number,
    output logic                           last_result
);

    dlfs_pkg::cfg_t    cfg_reg;
    dlfs_pkg::result_t res0, res1, head;
    logic [1:0]        push_cnt;
    logic              accept;
    logic              room_for_two;

    assign in_stall = !room_for_two;
    assign accept   = in_valid && room_for_two;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_reg.delim_first       <= dlfs_pkg::RST_DELIM_FIRST;
            cfg_reg.delim_second      <= dlfs_pkg::RST_DELIM_SECOND;
            cfg_reg.comment_mark      <= dlfs_pkg::RST_COMMENT_MARK;
            cfg_reg.drop_blank_lines  <= dlfs_pkg::RST_DROP_BLANK_LINES;
            cfg_reg.skip_empty_fields <= dlfs_pkg::RST_SKIP_EMPTY_FIELDS;
            cfg_reg.max_column        <= dlfs_pkg::RST_MAX_COLUMN;
            cfg_reg.column_map        <= dlfs_pkg::RST_COLUMN_MAP;
        end else if (cfg_we) begin
            case (cfg_index)
                dlfs_pkg::CFG_DELIM_FIRST:       cfg_reg.delim_first       <= cfg_data[7:0];
                dlfs_pkg::CFG_DELIM_SECOND:      cfg_reg.delim_second      <= cfg_data[7:0];
                dlfs_pkg::CFG_COMMENT_MARK:      cfg_reg.comment_mark      <= cfg_data[7:0];
                dlfs_pkg::CFG_DROP_BLANK_LINES:  cfg_reg.drop_blank_lines  <= cfg_data[0];
                dlfs_pkg::CFG_SKIP_EMPTY_FIELDS: cfg_reg.skip_empty_fields <= cfg_data[0];
                dlfs_pkg::CFG_MAX_COLUMN:        cfg_reg.max_column        <= cfg_data[3:0];
                dlfs_pkg::CFG_COLUMN_MAP:        cfg_reg.column_map        <= cfg_data;
                default: ;
            endcase
        end
    end

    dlfs_parse #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .SLOT_BITS   (SLOT_BITS)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .text_byte    (text_byte),
        .end_of_input (end_of_input),
        .cfg          (cfg_reg),
        .res0         (res0),
        .res1         (res1),
        .push_cnt     (push_cnt)
    );

    dlfs_result_fifo u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_data0     (res0),
        .wr_data1     (res1),
        .push_cnt     (push_cnt),
        .pop          (!out_stall),
        .rd_data      (head),
        .not_empty    (out_valid),
        .room_for_two (room_for_two)
    );

    assign out_byte     = head.out_byte;
    assign has_byte     = head.has_byte;
    assign slot         = head.slot;
    assign column_index = head.column_index;
    assign field_done   = head.field_done;
    assign line_done    = head.line_done;
    assign status       = head.status;
    assign line_number  = head.line_number;
    assign last_result  = head.last_result;

endmodule

### rtl/dlfs_parse.sv
module dlfs_parse #(
    parameter int MAX_COLUMNS = dlfs_pkg::MAX_COLUMNS_DEFAULT,
    parameter int SLOT_BITS   = dlfs_pkg::SLOT_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       text_byte,
    input  logic             end_of_input,
    input  dlfs_pkg::cfg_t   cfg,
    output dlfs_pkg::result_t res0,
    output dlfs_pkg::result_t res1,
    output logic [1:0]       push_cnt
);

    localparam logic [3:0] SLOT_MASK = 4'((1 << SLOT_BITS) - 1);
    localparam logic [3:0] COL_LIMIT = 4'(MAX_COLUMNS);

    dlfs_pkg::phase_t phase_reg, phase_next;
    logic [3:0]       cols_reg, cols_next;
    logic             fopen_reg, fopen_next;
    logic [31:0]      lines_reg, lines_next;

    logic             is_lf, is_eol, is_delim, is_comment;
    logic [3:0]       lim;
    logic [3:0]       cur_cols;
    logic             cur_fopen;
    logic [31:0]      num;
    logic             le_fd;
    logic [3:0]       le_col;
    logic [3:0]       fld_col;
    logic [3:0]       fld_slot;
    logic             fld_counted;
    logic             fld_done;
    logic [1:0]       res_cnt;
    dlfs_pkg::result_t le_res;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= dlfs_pkg::PH_START;
            cols_reg  <= '0;
            fopen_reg <= 1'b0;
            lines_reg <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            cols_reg  <= cols_next;
            fopen_reg <= fopen_next;
            lines_reg <= lines_next;
        end
    end

    always_comb begin
        is_lf      = (text_byte == dlfs_pkg::CH_LF);
        is_eol     = is_lf || (text_byte == dlfs_pkg::CH_CR);
        is_delim   = (text_byte == cfg.delim_first) || (text_byte == cfg.delim_second);
        is_comment = (cfg.comment_mark != 8'd0) && (text_byte == cfg.comment_mark);
        lim        = (cfg.max_column > COL_LIMIT) ? COL_LIMIT : cfg.max_column;

        // A new line starts with a clean column count.
        cur_cols  = (phase_reg == dlfs_pkg::PH_START) ? 4'd0 : cols_reg;
        cur_fopen = (phase_reg == dlfs_pkg::PH_START) ? 1'b0 : fopen_reg;
        num       = (phase_reg == dlfs_pkg::PH_START) ? lines_reg + 32'd1 : lines_reg;

        // Line end: an open field, or an empty one when empty fields count.
        le_fd  = cur_fopen || !cfg.skip_empty_fields;
        le_col = cur_fopen ? cur_cols
               : (cfg.skip_empty_fields ? cur_cols : dlfs_pkg::col_inc(cur_cols));
        le_res              = '0;
        le_res.slot         = le_fd ? dlfs_pkg::slot_of(cfg.column_map, le_col, SLOT_MASK)
                                    : 4'd0;
        le_res.column_index = le_col;
        le_res.field_done   = le_fd;
        le_res.line_done    = 1'b1;
        le_res.status       = (le_col >= lim) ? dlfs_pkg::ST_OK : dlfs_pkg::ST_FEW;
        le_res.line_number  = num;

        fld_col     = cur_fopen ? cur_cols : dlfs_pkg::col_inc(cur_cols);
        fld_slot    = dlfs_pkg::slot_of(cfg.column_map, fld_col, SLOT_MASK);
        fld_counted = cur_fopen || !cfg.skip_empty_fields;
        fld_done    = (fld_col >= lim);

        phase_next = phase_reg;
        cols_next  = cols_reg;
        fopen_next = fopen_reg;
        lines_next = lines_reg;
        res0       = '0;
        res1       = '0;
        res_cnt    = 2'd0;

        if (end_of_input) begin
            // A line still in content is closed before the end-of-file report.
            if (phase_reg == dlfs_pkg::PH_CONTENT) begin
                res0    = le_res;
                res_cnt = 2'd1;
            end
            res1             = '0;
            res1.status      = dlfs_pkg::ST_EOF;
            res1.line_number = lines_reg;
            res1.last_result = 1'b1;
            if (res_cnt == 2'd0) begin
                res0    = res1;
                res_cnt = 2'd1;
            end else begin
                res_cnt = 2'd2;
            end
            phase_next = dlfs_pkg::PH_START;
            cols_next  = '0;
            fopen_next = 1'b0;
        end else begin
            case (phase_reg)
                dlfs_pkg::PH_START,
                dlfs_pkg::PH_CONTENT: begin
                    lines_next = num;
                    cols_next  = cur_cols;
                    fopen_next = cur_fopen;
                    if (phase_reg == dlfs_pkg::PH_START && is_eol) begin
                        if (!cfg.drop_blank_lines) begin
                            res0    = le_res;
                            res_cnt = 2'd1;
                        end
                        phase_next = is_lf ? dlfs_pkg::PH_START : dlfs_pkg::PH_WAIT;
                        cols_next  = '0;
                        fopen_next = 1'b0;
                    end else if (phase_reg == dlfs_pkg::PH_START && is_comment) begin
                        phase_next = dlfs_pkg::PH_WAIT;
                    end else if (is_eol) begin
                        res0       = le_res;
                        res_cnt    = 2'd1;
                        phase_next = is_lf ? dlfs_pkg::PH_START : dlfs_pkg::PH_WAIT;
                        cols_next  = '0;
                        fopen_next = 1'b0;
                    end else if (is_delim) begin
                        phase_next = dlfs_pkg::PH_CONTENT;
                        if (fld_counted) begin
                            res0.slot         = fld_slot;
                            res0.column_index = fld_col;
                            res0.field_done   = 1'b1;
                            res0.line_done    = fld_done;
                            res0.status       = dlfs_pkg::ST_OK;
                            res0.line_number  = num;
                            res_cnt           = 2'd1;
                            fopen_next        = 1'b0;
                            cols_next         = fld_col;
                            // Reaching the column limit ends the line early.
                            if (fld_done) begin
                                phase_next = dlfs_pkg::PH_WAIT;
                                cols_next  = '0;
                            end
                        end
                    end else begin
                        phase_next = dlfs_pkg::PH_CONTENT;
                        cols_next  = fld_col;
                        fopen_next = 1'b1;
                        if (fld_slot != 4'd0) begin
                            res0.out_byte     = text_byte;
                            res0.has_byte     = 1'b1;
                            res0.slot         = fld_slot;
                            res0.column_index = fld_col;
                            res0.line_number  = num;
                            res_cnt           = 2'd1;
                        end
                    end
                    if (res_cnt != 2'd0) begin
                        res0.last_result = 1'b1;
                    end
                end
                default: begin
                    if (is_lf) begin
                        phase_next = dlfs_pkg::PH_START;
                    end
                end
            endcase
        end

        push_cnt = accept ? res_cnt : 2'd0;
    end

    // Only an end-of-input request can produce two results.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt == 2'd2) |-> end_of_input)
        else $error("two results from a text byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_input) |=> (phase_reg == dlfs_pkg::PH_START) && (cols_reg == 4'd0))
        else $error("splitter not back at line start after end of input");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !end_of_input && phase_reg == dlfs_pkg::PH_START)
        |=> (lines_reg == $past(lines_reg) + 32'd1))
        else $error("line count did not advance at a line start");

endmodule

### rtl/dlfs_result_fifo.sv
module dlfs_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  dlfs_pkg::result_t wr_data0,
    input  dlfs_pkg::result_t wr_data1,
    input  logic [1:0]        push_cnt,
    input  logic              pop,
    output dlfs_pkg::result_t rd_data,
    output logic              not_empty,
    output logic              room_for_two
);

    localparam logic [dlfs_pkg::RES_CNT_W-1:0] DEPTH_CNT =
        dlfs_pkg::RES_CNT_W'(dlfs_pkg::RES_DEPTH);

    dlfs_pkg::result_t mem_reg [dlfs_pkg::RES_DEPTH];
    logic [dlfs_pkg::RES_PTR_W-1:0] wptr_reg, wptr_next;
    logic [dlfs_pkg::RES_PTR_W-1:0] rptr_reg, rptr_next;
    logic [dlfs_pkg::RES_CNT_W-1:0] count_reg, count_next;
    logic [dlfs_pkg::RES_PTR_W-1:0] wptr_plus1;
    logic                           do_pop;

    assign wptr_plus1   = wptr_reg + 1'b1;
    assign do_pop       = pop && not_empty;
    assign not_empty    = (count_reg != '0);
    assign room_for_two = (count_reg <= DEPTH_CNT - 2'd2);
    assign rd_data      = mem_reg[rptr_reg];

    always_comb begin
        wptr_next  = wptr_reg + dlfs_pkg::RES_PTR_W'(push_cnt);
        rptr_next  = rptr_reg + dlfs_pkg::RES_PTR_W'(do_pop);
        count_next = count_reg + dlfs_pkg::RES_CNT_W'(push_cnt)
                   - dlfs_pkg::RES_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wptr_reg] <= wr_data0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wptr_plus1] <= wr_data1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("result queue overflow");

endmodule
